// ----- hdl/rtsps_pkg.sv -----
// ----------------------------------------------------------------------------
// rtsps_pkg
// shared types and constants of the round-trip shortest path sum block
// ----------------------------------------------------------------------------
package rtsps_pkg;

    localparam int NODE_W   = 11;
    localparam int COST_W   = 32;
    localparam int SUM_W    = 64;
    localparam int DIST_W   = 43;
    localparam int EDGE_W   = 2 * NODE_W + COST_W;
    localparam int QDEPTH   = 4;
    localparam int QAW      = 2;
    localparam int CFG_IW   = 2;

    localparam logic [CFG_IW-1:0] REG_NODE_COUNT  = 2'd0;
    localparam logic [CFG_IW-1:0] REG_SOURCE_NODE = 2'd1;

    localparam logic [DIST_W-1:0] DIST_UNREACHED = {DIST_W{1'b1}};

    typedef struct packed {
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
        logic [COST_W-1:0] weight;
        logic              last;
    } edge_t;

    typedef struct packed {
        logic [NODE_W-1:0] node_count;
        logic [NODE_W-1:0] source_node;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_EDGE_RD,
        ST_DIST_RD,
        ST_RELAX,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_EMIT
    } state_t;

endpackage

// ----- hdl/rtsps_ram.sv -----
// ----------------------------------------------------------------------------
// rtsps_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module rtsps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/rtsps_front.sv -----
// ----------------------------------------------------------------------------
// rtsps_front
// configuration registers and edge intake toward the queue
// ----------------------------------------------------------------------------
module rtsps_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rtsps_pkg::CFG_IW-1:0]      cfg_index,
    input  logic [rtsps_pkg::NODE_W-1:0]      cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic [rtsps_pkg::NODE_W-1:0]      edge_src,
    input  logic [rtsps_pkg::NODE_W-1:0]      edge_dst,
    input  logic [rtsps_pkg::COST_W-1:0]      edge_weight,
    input  logic                              last_edge,
    output rtsps_pkg::cfg_t                   cfg,
    output logic                              q_push,
    output rtsps_pkg::edge_t                  q_data,
    input  logic                              q_full
);

    logic [rtsps_pkg::NODE_W-1:0] node_count_reg, node_count_next;
    logic [rtsps_pkg::NODE_W-1:0] source_node_reg, source_node_next;

    always_comb
    begin
        node_count_next  = node_count_reg;
        source_node_next = source_node_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                rtsps_pkg::REG_NODE_COUNT:  node_count_next  = cfg_data;
                rtsps_pkg::REG_SOURCE_NODE: source_node_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg  <= rtsps_pkg::NODE_W'(1);
            source_node_reg <= rtsps_pkg::NODE_W'(1);
        end
        else
        begin
            node_count_reg  <= node_count_next;
            source_node_reg <= source_node_next;
        end
    end

    assign cfg.node_count  = node_count_reg;
    assign cfg.source_node = source_node_reg;

    assign full          = q_full;
    assign q_push        = push && !q_full;
    assign q_data.src    = edge_src;
    assign q_data.dst    = edge_dst;
    assign q_data.weight = edge_weight;
    assign q_data.last   = last_edge;

endmodule

// ----- hdl/rtsps_queue.sv -----
// ----------------------------------------------------------------------------
// rtsps_queue
// short edge queue between intake and compute engine
// ----------------------------------------------------------------------------
module rtsps_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr,
    input  rtsps_pkg::edge_t   wdata,
    output logic               q_full,
    input  logic               rd,
    output rtsps_pkg::edge_t   rdata,
    output logic               q_empty
);

    rtsps_pkg::edge_t            slot_reg [rtsps_pkg::QDEPTH];
    logic [rtsps_pkg::QAW-1:0]   wptr_reg, wptr_next;
    logic [rtsps_pkg::QAW-1:0]   rptr_reg, rptr_next;
    logic [rtsps_pkg::QAW:0]     cnt_reg, cnt_next;

    assign q_full  = (cnt_reg == (rtsps_pkg::QAW+1)'(rtsps_pkg::QDEPTH));
    assign q_empty = (cnt_reg == '0);
    assign rdata   = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (wr)
        begin
            wptr_next = wptr_reg + rtsps_pkg::QAW'(1);
        end
        if (rd)
        begin
            rptr_next = rptr_reg + rtsps_pkg::QAW'(1);
        end
        if (wr && !rd)
        begin
            cnt_next = cnt_reg + (rtsps_pkg::QAW+1)'(1);
        end
        else if (rd && !wr)
        begin
            cnt_next = cnt_reg - (rtsps_pkg::QAW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

endmodule

// ----- hdl/rtsps_back.sv -----
// ----------------------------------------------------------------------------
// rtsps_back
// edge storage, relaxation sweeps in both directions, sums and result slot
// ----------------------------------------------------------------------------
module rtsps_back #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rtsps_pkg::cfg_t                   cfg,
    input  logic                              q_empty,
    input  rtsps_pkg::edge_t                  q_data,
    output logic                              q_pop,
    output logic                              empty,
    input  logic                              pop,
    output logic [rtsps_pkg::SUM_W-1:0]       forward_sum,
    output logic [rtsps_pkg::SUM_W-1:0]       reverse_sum,
    output logic [rtsps_pkg::SUM_W-1:0]       total_sum,
    output logic                              unreachable,
    output logic                              saturated
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int DW  = rtsps_pkg::DIST_W;
    localparam int SW  = rtsps_pkg::SUM_W;
    localparam int VW  = rtsps_pkg::NODE_W;
    localparam int CW  = rtsps_pkg::COST_W;

    rtsps_pkg::state_t state_reg, state_next;

    logic [ECW-1:0] cnt_reg, cnt_next;
    logic [EAW-1:0] e_reg, e_next;
    logic [NW-1:0]  idx_reg, idx_next;
    logic [NCW-1:0] n_reg, n_next;
    logic [NW-1:0]  s_reg, s_next;
    logic [NW-1:0]  b_reg, b_next;
    logic           rev_reg, rev_next;
    logic           chg_reg, chg_next;
    logic [SW-1:0]  sum_reg, sum_next;
    logic [SW-1:0]  fwd_reg, fwd_next;
    logic           unr_reg, unr_next;
    logic           sat_reg, sat_next;
    logic           out_valid_reg, out_valid_next;
    logic [SW-1:0]  out_fwd_reg, out_fwd_next;
    logic [SW-1:0]  out_rev_reg, out_rev_next;
    logic [SW-1:0]  out_tot_reg, out_tot_next;
    logic           out_unr_reg, out_unr_next;
    logic           out_sat_reg, out_sat_next;

    logic                         e_we, e_re;
    logic [rtsps_pkg::EDGE_W-1:0] e_wdata, e_q;
    logic                         d_we, da_re, db_re;
    logic [NW-1:0]                d_waddr, da_raddr, db_raddr;
    logic [DW-1:0]                d_wdata, da_q, db_q;

    logic [VW-1:0] q_from, q_to, a_node, b_node;
    logic [CW-1:0] q_cost;
    logic          ends_ok, last_e, idx_last, store_ok, out_free;
    logic [DW:0]   nd;
    logic [SW:0]   acc, tot;
    logic [31:0]   n32, s32;

    assign q_from = e_q[rtsps_pkg::EDGE_W-1 -: VW];
    assign q_to   = e_q[CW +: VW];
    assign q_cost = e_q[CW-1:0];
    assign a_node = rev_reg ? q_to : q_from;
    assign b_node = rev_reg ? q_from : q_to;
    assign ends_ok = (a_node != '0) && (32'(a_node) <= 32'(n_reg))
                  && (b_node != '0) && (32'(b_node) <= 32'(n_reg));
    assign last_e   = ((ECW'(e_reg) + ECW'(1)) == cnt_reg);
    assign idx_last = ((NCW'(idx_reg) + NCW'(1)) == n_reg);
    assign store_ok = (32'(cnt_reg) < 32'(MAX_EDGES));
    assign out_free = !out_valid_reg || pop;
    assign nd  = {1'b0, da_q} + (DW+1)'(q_cost);
    assign acc = {1'b0, sum_reg} + (SW+1)'(da_q);
    assign tot = {1'b0, fwd_reg} + {1'b0, sum_reg};

    always_comb
    begin
        n32 = 32'(cfg.node_count);
        if (n32 == 32'd0)
        begin
            n32 = 32'd1;
        end
        else if (n32 > 32'(MAX_NODES))
        begin
            n32 = 32'(MAX_NODES);
        end
        s32 = 32'(cfg.source_node);
        if (s32 == 32'd0)
        begin
            s32 = 32'd1;
        end
        else if (s32 > n32)
        begin
            s32 = n32;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rtsps_pkg::ST_LOAD:
            begin
                if (!q_empty && q_data.last)
                begin
                    state_next = rtsps_pkg::ST_CLEAR;
                end
            end
            rtsps_pkg::ST_CLEAR:
            begin
                if (idx_last)
                begin
                    state_next = (cnt_reg == '0) ? rtsps_pkg::ST_SUM_RD
                                                 : rtsps_pkg::ST_EDGE_RD;
                end
            end
            rtsps_pkg::ST_EDGE_RD: state_next = rtsps_pkg::ST_DIST_RD;
            rtsps_pkg::ST_DIST_RD:
            begin
                if (ends_ok)
                begin
                    state_next = rtsps_pkg::ST_RELAX;
                end
                else if (last_e && !chg_reg)
                begin
                    state_next = rtsps_pkg::ST_SUM_RD;
                end
                else
                begin
                    state_next = rtsps_pkg::ST_EDGE_RD;
                end
            end
            rtsps_pkg::ST_RELAX:
            begin
                if (last_e && !chg_reg && !(nd < {1'b0, db_q}))
                begin
                    state_next = rtsps_pkg::ST_SUM_RD;
                end
                else
                begin
                    state_next = rtsps_pkg::ST_EDGE_RD;
                end
            end
            rtsps_pkg::ST_SUM_RD: state_next = rtsps_pkg::ST_SUM_ACC;
            rtsps_pkg::ST_SUM_ACC:
            begin
                if (!idx_last)
                begin
                    state_next = rtsps_pkg::ST_SUM_RD;
                end
                else if (!rev_reg)
                begin
                    state_next = rtsps_pkg::ST_CLEAR;
                end
                else
                begin
                    state_next = rtsps_pkg::ST_EMIT;
                end
            end
            rtsps_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = rtsps_pkg::ST_LOAD;
                end
            end
            default: state_next = rtsps_pkg::ST_LOAD;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        cnt_next       = cnt_reg;
        e_next         = e_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        s_next         = s_reg;
        b_next         = b_reg;
        rev_next       = rev_reg;
        chg_next       = chg_reg;
        sum_next       = sum_reg;
        fwd_next       = fwd_reg;
        unr_next       = unr_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg && !pop;
        out_fwd_next   = out_fwd_reg;
        out_rev_next   = out_rev_reg;
        out_tot_next   = out_tot_reg;
        out_unr_next   = out_unr_reg;
        out_sat_next   = out_sat_reg;
        q_pop          = 1'b0;
        e_we           = 1'b0;
        e_wdata        = {q_data.src, q_data.dst, q_data.weight};
        e_re           = 1'b0;
        d_we           = 1'b0;
        d_waddr        = idx_reg;
        d_wdata        = rtsps_pkg::DIST_UNREACHED;
        da_re          = 1'b0;
        da_raddr       = idx_reg;
        db_re          = 1'b0;
        db_raddr       = NW'(b_node - VW'(1));
        case (state_reg)
            rtsps_pkg::ST_LOAD:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (store_ok)
                    begin
                        e_we     = 1'b1;
                        cnt_next = cnt_reg + ECW'(1);
                    end
                    if (q_data.last)
                    begin
                        n_next   = NCW'(n32);
                        s_next   = NW'(s32 - 32'd1);
                        rev_next = 1'b0;
                        unr_next = 1'b0;
                        sat_next = 1'b0;
                        idx_next = '0;
                    end
                end
            end
            rtsps_pkg::ST_CLEAR:
            begin
                d_we = 1'b1;
                if (idx_reg == s_reg)
                begin
                    d_wdata = '0;
                end
                e_next   = '0;
                chg_next = 1'b0;
                sum_next = '0;
                idx_next = idx_last ? '0 : idx_reg + NW'(1);
            end
            rtsps_pkg::ST_EDGE_RD:
            begin
                e_re = 1'b1;
            end
            rtsps_pkg::ST_DIST_RD:
            begin
                if (ends_ok)
                begin
                    da_re    = 1'b1;
                    da_raddr = NW'(a_node - VW'(1));
                    db_re    = 1'b1;
                    b_next   = NW'(b_node - VW'(1));
                end
                else if (last_e)
                begin
                    e_next   = '0;
                    chg_next = 1'b0;
                end
                else
                begin
                    e_next = e_reg + EAW'(1);
                end
            end
            rtsps_pkg::ST_RELAX:
            begin
                d_waddr = b_reg;
                d_wdata = nd[DW-1:0];
                if (nd < {1'b0, db_q})
                begin
                    d_we = 1'b1;
                end
                if (last_e)
                begin
                    e_next   = '0;
                    chg_next = 1'b0;
                end
                else
                begin
                    e_next   = e_reg + EAW'(1);
                    chg_next = chg_reg || (nd < {1'b0, db_q});
                end
            end
            rtsps_pkg::ST_SUM_RD:
            begin
                da_re = 1'b1;
            end
            rtsps_pkg::ST_SUM_ACC:
            begin
                if (idx_reg != s_reg)
                begin
                    if (da_q == rtsps_pkg::DIST_UNREACHED)
                    begin
                        unr_next = 1'b1;
                    end
                    else if (acc[SW])
                    begin
                        sum_next = {SW{1'b1}};
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        sum_next = acc[SW-1:0];
                    end
                end
                idx_next = idx_last ? '0 : idx_reg + NW'(1);
                if (idx_last && !rev_reg)
                begin
                    fwd_next = (idx_reg != s_reg && da_q != rtsps_pkg::DIST_UNREACHED)
                             ? (acc[SW] ? {SW{1'b1}} : acc[SW-1:0]) : sum_reg;
                    rev_next = 1'b1;
                end
            end
            rtsps_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_fwd_next   = fwd_reg;
                    out_rev_next   = sum_reg;
                    out_tot_next   = tot[SW] ? {SW{1'b1}} : tot[SW-1:0];
                    out_unr_next   = unr_reg;
                    out_sat_next   = sat_reg || tot[SW];
                    cnt_next       = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rtsps_pkg::ST_LOAD;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg       <= e_next;
        idx_reg     <= idx_next;
        n_reg       <= n_next;
        s_reg       <= s_next;
        b_reg       <= b_next;
        rev_reg     <= rev_next;
        chg_reg     <= chg_next;
        sum_reg     <= sum_next;
        fwd_reg     <= fwd_next;
        unr_reg     <= unr_next;
        sat_reg     <= sat_next;
        out_fwd_reg <= out_fwd_next;
        out_rev_reg <= out_rev_next;
        out_tot_reg <= out_tot_next;
        out_unr_reg <= out_unr_next;
        out_sat_reg <= out_sat_next;
    end

    rtsps_ram #(.WIDTH(rtsps_pkg::EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (EAW'(cnt_reg)),
        .wdata (e_wdata),
        .re    (e_re),
        .raddr (e_reg),
        .rdata (e_q)
    );

    rtsps_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_dist_a_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .re    (da_re),
        .raddr (da_raddr),
        .rdata (da_q)
    );

    rtsps_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_dist_b_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .re    (db_re),
        .raddr (db_raddr),
        .rdata (db_q)
    );

    assign empty       = !out_valid_reg;
    assign forward_sum = out_fwd_reg;
    assign reverse_sum = out_rev_reg;
    assign total_sum   = out_tot_reg;
    assign unreachable = out_unr_reg;
    assign saturated   = out_sat_reg;

endmodule

// ----- hdl/round_trip_shortest_path_sum.sv -----
// ----------------------------------------------------------------------------
// round_trip_shortest_path_sum
// after the final edge: two passes, each a distance clear, at most n
//   relaxation sweeps over the stored edges until a sweep changes nothing,
//   and a sum over the nodes
// throughput: one edge per cycle while loading, set by the edge ram write port
// reset: config registers go to one, edge count and result slot are cleared
// ----------------------------------------------------------------------------
module round_trip_shortest_path_sum #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rtsps_pkg::CFG_IW-1:0]      cfg_index,
    input  logic [rtsps_pkg::NODE_W-1:0]      cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic [rtsps_pkg::NODE_W-1:0]      edge_src,
    input  logic [rtsps_pkg::NODE_W-1:0]      edge_dst,
    input  logic [rtsps_pkg::COST_W-1:0]      edge_weight,
    input  logic                              last_edge,
    output logic                              empty,
    input  logic                              pop,
    output logic [rtsps_pkg::SUM_W-1:0]       forward_sum,
    output logic [rtsps_pkg::SUM_W-1:0]       reverse_sum,
    output logic [rtsps_pkg::SUM_W-1:0]       total_sum,
    output logic                              unreachable,
    output logic                              saturated
);

    rtsps_pkg::cfg_t  cfg;
    rtsps_pkg::edge_t q_wdata, q_rdata;
    logic             q_push, q_full, q_pop, q_empty;

    rtsps_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .edge_src    (edge_src),
        .edge_dst    (edge_dst),
        .edge_weight (edge_weight),
        .last_edge   (last_edge),
        .cfg         (cfg),
        .q_push      (q_push),
        .q_data      (q_wdata),
        .q_full      (q_full)
    );

    rtsps_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_push),
        .wdata   (q_wdata),
        .q_full  (q_full),
        .rd      (q_pop),
        .rdata   (q_rdata),
        .q_empty (q_empty)
    );

    rtsps_back #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_empty     (q_empty),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .forward_sum (forward_sum),
        .reverse_sum (reverse_sum),
        .total_sum   (total_sum),
        .unreachable (unreachable),
        .saturated   (saturated)
    );

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for round_trip_shortest_path_sum: graphs of directed
// edges are pushed in, each graph's round-trip distance sums are given or
// solved by relaxation and compared field by field with each popped result
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MAXN = 1024;
    localparam int MAXE = 4096;

    typedef struct packed {
        logic [rtsps_pkg::SUM_W-1:0] fwd;
        logic [rtsps_pkg::SUM_W-1:0] rev;
        logic [rtsps_pkg::SUM_W-1:0] tot;
        logic                        unr;
        logic                        sat;
    } sums_t;

    typedef struct {
        bit               is_cfg;
        int               cfg_n;
        int               cfg_s;
        rtsps_pkg::edge_t e;
        bit               has_exp;
        sums_t            exp_val;
    } stim_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [rtsps_pkg::CFG_IW-1:0]   cfg_index;
    logic [rtsps_pkg::NODE_W-1:0]   cfg_data;
    logic                           push;
    logic                           full;
    logic [rtsps_pkg::NODE_W-1:0]   edge_src;
    logic [rtsps_pkg::NODE_W-1:0]   edge_dst;
    logic [rtsps_pkg::COST_W-1:0]   edge_weight;
    logic                           last_edge;
    logic                           empty;
    logic                           pop;
    logic [rtsps_pkg::SUM_W-1:0]    forward_sum;
    logic [rtsps_pkg::SUM_W-1:0]    reverse_sum;
    logic [rtsps_pkg::SUM_W-1:0]    total_sum;
    logic                           unreachable;
    logic                           saturated;

    round_trip_shortest_path_sum dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .push(push), .full(full),
        .edge_src(edge_src), .edge_dst(edge_dst),
        .edge_weight(edge_weight), .last_edge(last_edge),
        .empty(empty), .pop(pop),
        .forward_sum(forward_sum), .reverse_sum(reverse_sum),
        .total_sum(total_sum), .unreachable(unreachable), .saturated(saturated)
    );

    // predictor state
    logic [rtsps_pkg::NODE_W-1:0] node_count_q;
    logic [rtsps_pkg::NODE_W-1:0] source_node_q;
    rtsps_pkg::edge_t             graph_edges[$];
    logic [rtsps_pkg::DIST_W-1:0] dist_tab[MAXN];
    sums_t                        pending_sums[$];

    int  mismatches;
    int  send_idle;
    int  recv_stall;
    int  hold_len;
    bit  use_predictor;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [rtsps_pkg::SUM_W-1:0] solve_pass(bit rev, int n, int s,
                                                               inout bit unr, inout bit sat);
        logic [rtsps_pkg::SUM_W:0]   acc;
        logic [rtsps_pkg::SUM_W-1:0] nd;
        int                          a;
        int                          b;
        bit                          changed;
        acc = '0;
        for (int i = 0; i < MAXN; i++)
            dist_tab[i] = rtsps_pkg::DIST_UNREACHED;
        dist_tab[s-1] = '0;
        changed = 1'b1;
        while (changed)
        begin
            changed = 1'b0;
            foreach (graph_edges[k])
            begin
                a = rev ? graph_edges[k].dst : graph_edges[k].src;
                b = rev ? graph_edges[k].src : graph_edges[k].dst;
                if (a >= 1 && a <= n && b >= 1 && b <= n &&
                    dist_tab[a-1] != rtsps_pkg::DIST_UNREACHED)
                begin
                    nd = rtsps_pkg::SUM_W'(dist_tab[a-1])
                       + rtsps_pkg::SUM_W'(graph_edges[k].weight);
                    if (nd < rtsps_pkg::SUM_W'(dist_tab[b-1]))
                    begin
                        dist_tab[b-1] = nd[rtsps_pkg::DIST_W-1:0];
                        changed = 1'b1;
                    end
                end
            end
        end
        for (int i = 0; i < n; i++)
        begin
            if (i != s - 1)
            begin
                if (dist_tab[i] == rtsps_pkg::DIST_UNREACHED)
                    unr = 1'b1;
                else
                begin
                    acc = acc + dist_tab[i];
                    if (acc[rtsps_pkg::SUM_W])
                    begin
                        sat = 1'b1;
                        acc = {1'b0, {rtsps_pkg::SUM_W{1'b1}}};
                    end
                end
            end
        end
        return acc[rtsps_pkg::SUM_W-1:0];
    endfunction

    function automatic sums_t solve_round_trip();
        sums_t                     r;
        int                        n;
        int                        s;
        bit                        unr;
        bit                        sat;
        logic [rtsps_pkg::SUM_W:0] t;
        unr = 1'b0;
        sat = 1'b0;
        n = node_count_q;
        if (n < 1) n = 1;
        if (n > MAXN) n = MAXN;
        s = source_node_q;
        if (s < 1) s = 1;
        if (s > n) s = n;
        r.fwd = solve_pass(1'b0, n, s, unr, sat);
        r.rev = solve_pass(1'b1, n, s, unr, sat);
        t = r.fwd + r.rev;
        if (t[rtsps_pkg::SUM_W])
        begin
            sat = 1'b1;
            t = {1'b0, {rtsps_pkg::SUM_W{1'b1}}};
        end
        r.tot = t[rtsps_pkg::SUM_W-1:0];
        r.unr = unr;
        r.sat = sat;
        return r;
    endfunction

    // edge accepted by the block
    task automatic record_edge(rtsps_pkg::edge_t e, bit has_exp, sums_t exp_val);
        if (graph_edges.size() < MAXE)
            graph_edges = {graph_edges, e};
        if (e.last)
        begin
            if (has_exp)
                pending_sums = {pending_sums, exp_val};
            else
                pending_sums = {pending_sums, solve_round_trip()};
            graph_edges.delete();
        end
    endtask

    task automatic send_edge(rtsps_pkg::edge_t e, bit has_exp, sums_t exp_val);
        if ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle);
        end
        push        <= 1'b1;
        edge_src    <= e.src;
        edge_dst    <= e.dst;
        edge_weight <= e.weight;
        last_edge   <= e.last;
        do @(posedge clk); while (full);
        record_edge(e, has_exp, exp_val);
    endtask

    // drives push low and waits until nothing is in flight before configuring
    task automatic settle_and_configure(int n, int s);
        push <= 1'b0;
        wait (pending_sums.size() == 0);
        repeat (20) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= rtsps_pkg::REG_NODE_COUNT;
        cfg_data  <= rtsps_pkg::NODE_W'(n);
        @(posedge clk);
        cfg_index <= rtsps_pkg::REG_SOURCE_NODE;
        cfg_data  <= rtsps_pkg::NODE_W'(s);
        @(posedge clk);
        cfg_we <= 1'b0;
        node_count_q  = rtsps_pkg::NODE_W'(n);
        source_node_q = rtsps_pkg::NODE_W'(s);
        @(posedge clk);
    endtask

    function automatic logic [rtsps_pkg::COST_W-1:0] pick_weight();
        case ($urandom_range(3))
            0: return '0;
            1: return {rtsps_pkg::COST_W{1'b1}};
            2: return rtsps_pkg::COST_W'($urandom_range(0, 100));
            default: return rtsps_pkg::COST_W'($urandom);
        endcase
    endfunction

    task automatic send_graph(int n, int edges);
        rtsps_pkg::edge_t e;
        sums_t            none;
        none = '0;
        for (int k = 0; k < edges; k++)
        begin
            if ($urandom_range(9) == 0)
            begin
                e.src = rtsps_pkg::NODE_W'($urandom_range(0, 2047));
                e.dst = rtsps_pkg::NODE_W'($urandom_range(0, 2047));
            end
            else
            begin
                e.src = rtsps_pkg::NODE_W'($urandom_range(1, n));
                e.dst = rtsps_pkg::NODE_W'($urandom_range(1, n));
            end
            e.weight = pick_weight();
            e.last   = (k == edges - 1);
            send_edge(e, 1'b0, none);
        end
    endtask

    task automatic random_segment(int items);
        int n;
        int nc;
        int s;
        int sent;
        int ge;
        if ($urandom_range(9) == 0)
        begin
            case ($urandom_range(4))
                0: n = 0;
                1: n = 1;
                2: n = 1024;
                3: n = 2047;
                default: n = 1500;
            endcase
        end
        else
            n = $urandom_range(2, 12);
        nc = (n < 1) ? 1 : ((n > MAXN) ? MAXN : n);
        s  = ($urandom_range(9) == 0) ? 2047 : $urandom_range(0, nc + 1);
        settle_and_configure(n, s);
        sent = 0;
        while (sent < items)
        begin
            ge = (nc > 100) ? $urandom_range(1, 8) : $urandom_range(1, 2 * nc + 2);
            send_graph(nc, ge);
            sent += ge;
        end
    endtask

    // result side
    task automatic check_result();
        sums_t got;
        sums_t want;
        got = '{forward_sum, reverse_sum, total_sum, unreachable, saturated};
        if (pending_sums.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: fwd=%0h rev=%0h tot=%0h unr=%0b sat=%0b",
                         got.fwd, got.rev, got.tot, got.unr, got.sat);
            return;
        end
        want = pending_sums.pop_front();
        if (got.fwd !== want.fwd || got.rev !== want.rev || got.tot !== want.tot ||
            got.unr !== want.unr || got.sat !== want.sat)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp fwd=%0h rev=%0h tot=%0h unr=%0b sat=%0b / act fwd=%0h rev=%0h tot=%0h unr=%0b sat=%0b",
                         want.fwd, want.rev, want.tot, want.unr, want.sat,
                         got.fwd, got.rev, got.tot, got.unr, got.sat);
        end
    endtask

    initial
    begin
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                check_result();
            if (hold_len > 0)
            begin
                hold_len--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= recv_stall);
        end
    end

    function automatic stim_row_t cfg_row(int n, int s);
        stim_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.cfg_n  = n;
        r.cfg_s  = s;
        return r;
    endfunction

    function automatic stim_row_t edge_row(int a, int b, logic [rtsps_pkg::COST_W-1:0] w,
                                           bit l);
        stim_row_t r;
        r = '{default: '0};
        r.e = '{rtsps_pkg::NODE_W'(a), rtsps_pkg::NODE_W'(b), w, l};
        return r;
    endfunction

    function automatic stim_row_t typed(stim_row_t r, logic [rtsps_pkg::SUM_W-1:0] f,
                                        logic [rtsps_pkg::SUM_W-1:0] v, bit u);
        r.has_exp = 1'b1;
        r.exp_val = '{f, v, f + v, u, 1'b0};
        return r;
    endfunction

    initial
    begin
        stim_row_t        dir_rows[$];
        rtsps_pkg::edge_t e;
        sums_t            none;
        int               mode_idle[4];
        int               mode_stall[4];

        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        push = 1'b0;
        edge_src = '0;
        edge_dst = '0;
        edge_weight = '0;
        last_edge = 1'b0;
        mismatches = 0;
        send_idle = 0;
        recv_stall = 0;
        hold_len = 0;
        node_count_q = 1;
        source_node_q = 1;
        none = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, reset config first
        dir_rows = {dir_rows, typed(edge_row(1, 1, 0, 1), 0, 0, 0)};
        dir_rows = {dir_rows, typed(edge_row(0, 2047, {rtsps_pkg::COST_W{1'b1}}, 1), 0, 0, 0)};
        dir_rows = {dir_rows, cfg_row(2, 1)};
        dir_rows = {dir_rows, edge_row(1, 2, {rtsps_pkg::COST_W{1'b1}}, 0)};
        dir_rows = {dir_rows, typed(edge_row(2, 1, {rtsps_pkg::COST_W{1'b1}}, 1),
                                    64'hFFFF_FFFF, 64'hFFFF_FFFF, 0)};
        dir_rows = {dir_rows, typed(edge_row(1, 2, 7, 1), 7, 0, 1)};
        dir_rows = {dir_rows, cfg_row(0, 1)};
        dir_rows = {dir_rows, typed(edge_row(1, 2, 3, 1), 0, 0, 0)};
        dir_rows = {dir_rows, cfg_row(2047, 0)};
        dir_rows = {dir_rows, typed(edge_row(1, 1024, 1, 1), 1, 0, 1)};
        dir_rows = {dir_rows, cfg_row(3, 2047)};
        dir_rows = {dir_rows, edge_row(3, 1, 10, 0)};
        dir_rows = {dir_rows, edge_row(1, 2, 20, 0)};
        dir_rows = {dir_rows, edge_row(2, 3, 30, 0)};
        dir_rows = {dir_rows, edge_row(3, 2, 100, 1)};
        dir_rows = {dir_rows, cfg_row(3, 2)};
        dir_rows = {dir_rows, edge_row(2, 1, 0, 0)};
        dir_rows = {dir_rows, typed(edge_row(1, 2, 0, 1), 0, 0, 1)};
        dir_rows = {dir_rows, cfg_row(1024, 1024)};
        dir_rows = {dir_rows, edge_row(1024, 1, 5, 0)};
        dir_rows = {dir_rows, edge_row(1, 1024, 9, 1)};
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                settle_and_configure(dir_rows[i].cfg_n, dir_rows[i].cfg_s);
            else
                send_edge(dir_rows[i].e, dir_rows[i].has_exp, dir_rows[i].exp_val);
        end

        mode_idle  = '{0, 82, 0, 10};
        mode_stall = '{0, 0, 82, 10};
        for (int m = 0; m < 4; m++)
        begin
            send_idle  = mode_idle[m];
            recv_stall = mode_stall[m];
            for (int g = 0; g < 8; g++)
                random_segment(20);
        end

        // long receiver hold-off while one-edge graphs keep coming
        send_idle = 0;
        recv_stall = 0;
        settle_and_configure(2, 1);
        hold_len = 3000;
        for (int k = 0; k < 40; k++)
        begin
            e = '{rtsps_pkg::NODE_W'($urandom_range(1, 2)),
                  rtsps_pkg::NODE_W'($urandom_range(1, 2)),
                  pick_weight(), 1'b1};
            send_edge(e, 1'b0, none);
        end
        push <= 1'b0;
        wait (pending_sums.size() == 0);
        send_idle = 40;
        recv_stall = 40;
        for (int g = 0; g < 4; g++)
            random_segment(20);

        push <= 1'b0;
        wait (pending_sums.size() == 0);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && pending_sums.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #400000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/rtsps_pkg.sv
hdl/rtsps_ram.sv
hdl/rtsps_front.sv
hdl/rtsps_queue.sv
hdl/rtsps_back.sv
hdl/round_trip_shortest_path_sum.sv
tb/sv/tb_top.sv
